>>> design/grid_fan_ray_tracer_macros.svh
// Assertion macros for the grid fan ray tracer checker.
// No dependencies; included by the checker file.
`ifndef GRID_FAN_RAY_TRACER_MACROS_SVH
`define GRID_FAN_RAY_TRACER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GFRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid fan ray tracer check failed");

// Next-cycle implication, disabled in reset.
`define GFRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid fan ray tracer check failed");

`endif

>>> design/gfrt_pkg.sv
// Shared types, codes and the sine table of the grid fan ray tracer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gfrt_pkg;

    localparam int MAP_W_DEF = 512;
    localparam int MAP_H_DEF = 512;

    // opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TRACE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_SIGHT = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;

    // cell classes
    localparam logic [3:0] CLS_GREEN  = 4'd1;
    localparam logic [3:0] CLS_PINK   = 4'd2;
    localparam logic [3:0] CLS_BLACK  = 4'd3;
    localparam logic [3:0] CLS_OBJ_LO = 4'd4;
    localparam logic [3:0] CLS_OBJ_HI = 4'd13;
    localparam logic [3:0] OBJ_BIAS   = 4'd3;

    // register indexes
    localparam logic [1:0] CFG_RAY_LEN  = 2'd0;
    localparam logic [1:0] CFG_HALF_FAN = 2'd1;
    localparam logic [1:0] CFG_COLS     = 2'd2;
    localparam logic [1:0] CFG_ROWS     = 2'd3;

    localparam logic [5:0] RST_RAY_LEN  = 6'd45;
    localparam logic [6:0] RST_HALF_FAN = 7'd45;
    localparam logic [9:0] RST_COLS     = 10'd512;
    localparam logic [9:0] RST_ROWS     = 10'd512;

    localparam logic [9:0] TURN_DEG    = 10'd360;
    localparam logic [9:0] HALF_DEG    = 10'd180;
    localparam logic [9:0] QUARTER_DEG = 10'd90;
    localparam logic [9:0] THREEQ_DEG  = 10'd270;

    localparam int PW  = 28;  // position, Q11.16 signed plus margin
    localparam int SW  = 23;  // step, signed
    localparam int NW  = 7;   // step count
    localparam int CW  = 12;  // cell coordinate
    localparam int LW  = 14;  // edge limit
    localparam int CFG_DW = 10;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic [1:0] opcode;
        logic [8:0] cell_x;
        logic [8:0] cell_y;
        logic [3:0] cell_class;
        logic [8:0] heading_deg;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  cell_value;
        logic [3:0]  object_number;
        logic [8:0]  origin_x;
        logic [8:0]  origin_y;
        logic [15:0] trace_index;
        logic [12:0] green_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic signed [SW-1:0] step_x;
        logic signed [SW-1:0] step_y;
        logic [NW-1:0]        nsteps;
    } t_ray_res;

    typedef logic [15:0] t_sin_tab [0:90];

    // sin(d) * 32768 from the odd series up to x^13, Q30 arithmetic
    function automatic logic [15:0] sin_entry(input int unsigned d);
        longint unsigned xr;
        longint unsigned t;
        longint acc;
        xr  = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        t   = xr;
        acc = longint'(xr);
        t = (((t * xr) >> 30) * xr) >> 30;  t = t / 64'd6;   acc = acc - longint'(t);
        t = (((t * xr) >> 30) * xr) >> 30;  t = t / 64'd20;  acc = acc + longint'(t);
        t = (((t * xr) >> 30) * xr) >> 30;  t = t / 64'd42;  acc = acc - longint'(t);
        t = (((t * xr) >> 30) * xr) >> 30;  t = t / 64'd72;  acc = acc + longint'(t);
        t = (((t * xr) >> 30) * xr) >> 30;  t = t / 64'd110; acc = acc - longint'(t);
        t = (((t * xr) >> 30) * xr) >> 30;  t = t / 64'd156; acc = acc + longint'(t);
        if (acc < 0) acc = 0;
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32768) acc = 64'sd32768;
        return 16'(acc);
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        for (int d = 0; d <= 90; d++) begin
            tab[d] = sin_entry(d);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // signed sine of a whole angle 0..359, folded onto the quarter table
    function automatic logic signed [16:0] sin_deg(input logic [8:0] a);
        logic [9:0] aw;
        logic [9:0] idx;
        logic       neg;
        aw = {1'b0, a};
        if (aw <= QUARTER_DEG) begin
            idx = aw;               neg = 1'b0;
        end else if (aw <= HALF_DEG) begin
            idx = HALF_DEG - aw;    neg = 1'b0;
        end else if (aw <= THREEQ_DEG) begin
            idx = aw - HALF_DEG;    neg = 1'b1;
        end else begin
            idx = TURN_DEG - aw;    neg = 1'b1;
        end
        return neg ? -$signed({1'b0, SIN_TAB[idx[6:0]]}) : $signed({1'b0, SIN_TAB[idx[6:0]]});
    endfunction

endpackage

>>> design/gfrt_map.sv
// Class-coded grid map: one write port and one registered read port.
// Depends on gfrt_pkg for the default map size.
`timescale 1ns / 1ps

module gfrt_map import gfrt_pkg::*; #(
    parameter int MAP_W = MAP_W_DEF,
    parameter int MAP_H = MAP_H_DEF,
    localparam int AW   = $clog2(MAP_W * MAP_H)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [3:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [3:0]    o_rdata
);

    logic [3:0] mem [0:MAP_W*MAP_H-1];
    logic [3:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // holds its value between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/gfrt_ray.sv
// Per-ray setup: end point, step count (bitwise square root) and
// fixed-point step sizes (restoring divider, two lanes). Uses gfrt_pkg.
`timescale 1ns / 1ps

module gfrt_ray import gfrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [8:0]  i_x0,
    input  logic [8:0]  i_y0,
    input  logic [5:0]  i_len,
    input  logic [8:0]  i_ang,
    output logic        o_done,
    output t_ray_res    o_res
);

    localparam int DVW = 22;

    typedef enum logic [6:0] {
        R_IDLE  = 7'b0000001,
        R_MUL   = 7'b0000010,
        R_DELTA = 7'b0000100,
        R_SQ    = 7'b0001000,
        R_SQRT  = 7'b0010000,
        R_DIV   = 7'b0100000,
        R_FIN   = 7'b1000000
    } t_ray_state;

    t_ray_state r_state, n_state;

    logic signed [16:0] r_sn, r_cs;
    logic signed [23:0] r_lsn, r_lcs;
    logic signed [7:0]  r_ddx, r_ddy;
    logic [12:0]        r_sq;
    logic [NW-1:0]      r_root;
    logic [2:0]         r_bit;
    logic [NW-1:0]      r_nst;
    logic [DVW-1:0]     r_dvx, r_dvy;
    logic [NW-1:0]      r_rmx, r_rmy;
    logic [4:0]         r_cnt;

    logic [8:0]         cos_ang;
    logic signed [25:0] sum_x, sum_y;
    logic signed [7:0]  ddx, ddy;
    logic signed [15:0] sqx, sqy;
    logic [NW-1:0]      trial, n_root;
    logic [13:0]        trial_sq;
    logic [7:0]         abs_x, abs_y;
    logic [NW:0]        tx, ty;
    logic               gex, gey;

    // trunc-toward-zero of s / 2^15, minus the origin
    function automatic logic signed [7:0] delta(input logic signed [25:0] s,
                                                input logic [8:0] o);
        logic [25:0]        mag;
        logic signed [25:0] e;
        mag = s[25] ? 26'(-s) : 26'(s);
        e   = s[25] ? -$signed(mag >> 15) : $signed(mag >> 15);
        return 8'(e - $signed({17'b0, o}));
    endfunction

    assign cos_ang = ({1'b0, i_ang} >= THREEQ_DEG) ? 9'({1'b0, i_ang} - THREEQ_DEG)
                                                   : 9'({1'b0, i_ang} + QUARTER_DEG);

    assign sum_x = $signed({2'b0, i_x0, 15'b0}) + 26'(r_lcs);
    assign sum_y = $signed({2'b0, i_y0, 15'b0}) - 26'(r_lsn);
    assign ddx   = delta(sum_x, i_x0);
    assign ddy   = delta(sum_y, i_y0);
    assign sqx   = r_ddx * r_ddx;
    assign sqy   = r_ddy * r_ddy;

    assign trial    = r_root | (NW'(1) << r_bit);
    assign trial_sq = trial * trial;
    assign n_root   = (trial_sq <= {1'b0, r_sq}) ? trial : r_root;

    assign abs_x = r_ddx[7] ? 8'(-r_ddx) : 8'(r_ddx);
    assign abs_y = r_ddy[7] ? 8'(-r_ddy) : 8'(r_ddy);

    assign tx  = {r_rmx, r_dvx[DVW-1]};
    assign ty  = {r_rmy, r_dvy[DVW-1]};
    assign gex = tx >= {1'b0, r_nst};
    assign gey = ty >= {1'b0, r_nst};

    always_comb begin
        n_state = r_state;
        case (r_state)
            R_IDLE:  if (i_start) n_state = R_MUL;
            R_MUL:   n_state = R_DELTA;
            R_DELTA: n_state = R_SQ;
            R_SQ:    n_state = R_SQRT;
            R_SQRT:  if (r_bit == 3'd0) n_state = R_DIV;
            R_DIV:   if (r_cnt == 5'd0) n_state = R_FIN;
            R_FIN:   n_state = R_IDLE;
            default: n_state = R_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            R_IDLE: begin
                r_sn <= sin_deg(i_ang);
                r_cs <= sin_deg(cos_ang);
            end
            R_MUL: begin
                r_lcs <= $signed({1'b0, i_len}) * r_cs;
                r_lsn <= $signed({1'b0, i_len}) * r_sn;
            end
            R_DELTA: begin
                r_ddx <= ddx;
                r_ddy <= ddy;
            end
            R_SQ: begin
                r_sq   <= 13'(sqx + sqy);
                r_root <= '0;
                r_bit  <= 3'(NW - 1);
            end
            R_SQRT: begin
                r_root <= n_root;
                r_bit  <= r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    r_nst <= n_root + NW'(1);
                    r_dvx <= {abs_x[5:0], 16'b0};
                    r_dvy <= {abs_y[5:0], 16'b0};
                    r_rmx <= '0;
                    r_rmy <= '0;
                    r_cnt <= 5'(DVW - 1);
                end
            end
            R_DIV: begin
                r_rmx <= gex ? NW'(tx - {1'b0, r_nst}) : NW'(tx);
                r_rmy <= gey ? NW'(ty - {1'b0, r_nst}) : NW'(ty);
                r_dvx <= {r_dvx[DVW-2:0], gex};
                r_dvy <= {r_dvy[DVW-2:0], gey};
                r_cnt <= r_cnt - 5'd1;
            end
            default: ;
        endcase
    end

    assign o_done       = (r_state == R_FIN);
    assign o_res.step_x = r_ddx[7] ? -$signed({1'b0, r_dvx}) : $signed({1'b0, r_dvx});
    assign o_res.step_y = r_ddy[7] ? -$signed({1'b0, r_dvy}) : $signed({1'b0, r_dvy});
    assign o_res.nsteps = r_nst;

endmodule

>>> design/grid_fan_ray_tracer.sv
// Grid fan ray tracer top level: handshakes, sequencer, config registers.
// Depends on gfrt_pkg, gfrt_map and gfrt_ray.
//
//  channel  | signals                                 | moves
//  ---------+-----------------------------------------+---------------------------
//  in       | i_in_valid  o_in_ready  i_in_item       | one command item
//  out      | o_out_valid i_out_ready o_out_item      | one result item
//  cfg      | i_cfg_valid o_cfg_ready i_cfg_index/data| one register write
//
// A write is done on accept; a read waits for a free output register.
// Trace: per ray, setup in the shared ray unit (square root 7 steps,
// divider 22 steps), then per sample a map read, then evaluate and write
// back. Reset clears config, seen objects, trace counter and the output
// register; the map itself is not cleared. A full output register stalls a
// read result, a sighting or the final count; the next item is taken once
// the previous one is finished.
`timescale 1ns / 1ps

module grid_fan_ray_tracer import gfrt_pkg::*; #(
    parameter int MAP_W = MAP_W_DEF,
    parameter int MAP_H = MAP_H_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAP_W * MAP_H);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RD_OUT   = 7'b0000010,
        S_RAY_GO   = 7'b0000100,
        S_RAY_WAIT = 7'b0001000,
        S_STEP_RD  = 7'b0010000,
        S_STEP_EV  = 7'b0100000,
        S_COUNT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [5:0] r_cfg_len;
    logic [6:0] r_cfg_hf;
    logic [9:0] r_cfg_cols, r_cfg_rows;

    // persistent state
    logic [9:0]  r_seen,  n_seen;
    logic [15:0] r_tcnt,  n_tcnt;

    // trace context
    logic [8:0]          r_x0, n_x0, r_y0, n_y0;
    logic [LW-1:0]       r_xl, n_xl, r_yl, n_yl;
    logic [8:0]          r_ang, n_ang;
    logic [7:0]          r_k, n_k, r_nrays, n_nrays;
    logic signed [PW-1:0] r_px, n_px, r_py, n_py;
    logic [NW-1:0]       r_t, n_t;
    t_ray_res            r_ray, n_ray;
    logic [12:0]         r_greens, n_greens;
    logic                r_rd_in, n_rd_in;

    // output register
    logic      r_out_valid;
    t_out_item r_out;
    logic      emit;
    t_out_item emit_item;
    logic      out_free;

    // map port
    logic          map_we, map_re;
    logic [AW-1:0] map_waddr, map_raddr;
    logic [3:0]    map_wdata, map_rdata;

    // ray unit
    logic     ray_start, ray_done;
    t_ray_res ray_res;

    logic          in_acc, in_map, end_ray, advance;
    logic [AW-1:0] io_addr, step_addr;
    logic [CW:0]   pick_x, pick_y;
    logic [8:0]    head_mod;
    logic [9:0]    start_ang;
    logic [3:0]    code, obj_idx;
    logic          obj_new;

    // nearest cell along one axis, upper edge clamped: {in map, cell}
    function automatic logic [CW:0] pick(input logic signed [PW-1:0] p,
                                         input logic [LW-1:0] lim);
        logic [CW-1:0] w;
        if (p[PW-1]) begin
            // only -1 < p < 0 truncates to cell 0
            w = '0;
            return {(&p[PW-1:16]) && (p[15:0] != 16'd0) && (lim != '0), w};
        end
        w = p[CW+15:16];
        if (p[15] && ((LW'(w) + LW'(1)) < lim)) w = w + CW'(1);
        return {(LW'(w) < lim), w};
    endfunction

    gfrt_map #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    gfrt_ray u_ray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ray_start),
        .i_x0    (r_x0),
        .i_y0    (r_y0),
        .i_len   (r_cfg_len),
        .i_ang   (r_ang),
        .o_done  (ray_done),
        .o_res   (ray_res)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    assign in_map  = (LW'(i_in_item.cell_x) < LW'(MAP_W)) &&
                     (LW'(i_in_item.cell_y) < LW'(MAP_H));
    assign io_addr = AW'(i_in_item.cell_y) * AW'(MAP_W) + AW'(i_in_item.cell_x);

    assign pick_x    = pick(r_px, r_xl);
    assign pick_y    = pick(r_py, r_yl);
    assign step_addr = AW'(pick_y[CW-1:0]) * AW'(MAP_W) + AW'(pick_x[CW-1:0]);

    // heading mod 360, then back off by half the fan
    assign head_mod  = ({1'b0, i_in_item.heading_deg} >= TURN_DEG)
                       ? 9'({1'b0, i_in_item.heading_deg} - TURN_DEG)
                       : i_in_item.heading_deg;
    assign start_ang = (head_mod < {2'b0, r_cfg_hf})
                       ? ({1'b0, head_mod} + TURN_DEG - {3'b0, r_cfg_hf})
                       : ({1'b0, head_mod} - {3'b0, r_cfg_hf});

    assign code    = map_rdata;
    assign obj_idx = code - CLS_OBJ_LO;
    assign obj_new = (code >= CLS_OBJ_LO) && (code <= CLS_OBJ_HI) && !r_seen[obj_idx];

    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_tcnt    = r_tcnt;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_xl      = r_xl;
        n_yl      = r_yl;
        n_ang     = r_ang;
        n_k       = r_k;
        n_nrays   = r_nrays;
        n_px      = r_px;
        n_py      = r_py;
        n_t       = r_t;
        n_ray     = r_ray;
        n_greens  = r_greens;
        n_rd_in   = r_rd_in;
        map_we    = 1'b0;
        map_waddr = io_addr;
        map_wdata = i_in_item.cell_class;
        map_re    = 1'b0;
        map_raddr = io_addr;
        ray_start = 1'b0;
        emit      = 1'b0;
        emit_item = '0;
        end_ray   = 1'b0;
        advance   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.opcode)
                        OP_WRITE: map_we = in_map;
                        OP_READ: begin
                            map_re  = 1'b1;
                            n_rd_in = in_map;
                            n_state = S_RD_OUT;
                        end
                        OP_TRACE: begin
                            n_x0     = i_in_item.cell_x;
                            n_y0     = i_in_item.cell_y;
                            n_xl     = (LW'(r_cfg_cols) < LW'(MAP_W)) ? LW'(r_cfg_cols)
                                                                       : LW'(MAP_W);
                            n_yl     = (LW'(r_cfg_rows) < LW'(MAP_H)) ? LW'(r_cfg_rows)
                                                                       : LW'(MAP_H);
                            n_ang    = start_ang[8:0];
                            n_k      = '0;
                            n_nrays  = {r_cfg_hf, 1'b0};
                            n_greens = '0;
                            n_state  = (r_cfg_hf == '0) ? S_COUNT : S_RAY_GO;
                        end
                        default: ;  // unused opcode: dropped
                    endcase
                end
            end
            S_RD_OUT: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_item.kind       = KIND_READ;
                    emit_item.cell_value = r_rd_in ? map_rdata : 4'd0;
                    emit_item.last       = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_RAY_GO: begin
                ray_start = 1'b1;
                n_state   = S_RAY_WAIT;
            end
            S_RAY_WAIT: begin
                if (ray_done) begin
                    n_ray   = ray_res;
                    n_px    = $signed({3'b0, r_x0, 16'b0});
                    n_py    = $signed({3'b0, r_y0, 16'b0});
                    n_t     = '0;
                    n_state = S_STEP_RD;
                end
            end
            S_STEP_RD: begin
                if (pick_x[CW] && pick_y[CW]) begin
                    map_re    = 1'b1;
                    map_raddr = step_addr;
                    n_state   = S_STEP_EV;
                end else begin
                    end_ray = 1'b1;
                end
            end
            S_STEP_EV: begin
                if (code == CLS_GREEN) begin
                    // green turns pink; address still matches this sample
                    map_we    = 1'b1;
                    map_waddr = step_addr;
                    map_wdata = CLS_PINK;
                    n_greens  = (&r_greens) ? r_greens : r_greens + 13'd1;
                    advance   = 1'b1;
                end else if (obj_new) begin
                    if (out_free) begin
                        emit                    = 1'b1;
                        emit_item.kind          = KIND_SIGHT;
                        emit_item.object_number = code - OBJ_BIAS;
                        emit_item.origin_x      = r_x0;
                        emit_item.origin_y      = r_y0;
                        emit_item.trace_index   = r_tcnt;
                        n_seen[obj_idx]         = 1'b1;
                        advance                 = 1'b1;
                    end
                end else if (code == CLS_BLACK) begin
                    end_ray = 1'b1;
                end else begin
                    advance = 1'b1;
                end
            end
            S_COUNT: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    emit_item.kind        = KIND_COUNT;
                    emit_item.origin_x    = r_x0;
                    emit_item.origin_y    = r_y0;
                    emit_item.trace_index = r_tcnt;
                    emit_item.green_count = r_greens;
                    emit_item.last        = 1'b1;
                    n_tcnt                = r_tcnt + 16'd1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (advance) begin
            n_px = r_px + PW'(r_ray.step_x);
            n_py = r_py + PW'(r_ray.step_y);
            n_t  = r_t + NW'(1);
            if ((r_t + NW'(1)) == r_ray.nsteps) begin
                end_ray = 1'b1;
            end else begin
                n_state = S_STEP_RD;
            end
        end

        // next ray of the fan, or the count when the fan is done
        if (end_ray) begin
            n_ang   = ({1'b0, r_ang} == (TURN_DEG - 10'd1)) ? 9'd0 : r_ang + 9'd1;
            n_k     = r_k + 8'd1;
            n_state = ((r_k + 8'd1) == r_nrays) ? S_COUNT : S_RAY_GO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_tcnt      <= '0;
            r_out_valid <= 1'b0;
            r_cfg_len   <= RST_RAY_LEN;
            r_cfg_hf    <= RST_HALF_FAN;
            r_cfg_cols  <= RST_COLS;
            r_cfg_rows  <= RST_ROWS;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_tcnt  <= n_tcnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RAY_LEN:  r_cfg_len  <= i_cfg_data[5:0];
                    CFG_HALF_FAN: r_cfg_hf   <= i_cfg_data[6:0];
                    CFG_COLS:     r_cfg_cols <= i_cfg_data;
                    CFG_ROWS:     r_cfg_rows <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_xl     <= n_xl;
        r_yl     <= n_yl;
        r_ang    <= n_ang;
        r_k      <= n_k;
        r_nrays  <= n_nrays;
        r_px     <= n_px;
        r_py     <= n_py;
        r_t      <= n_t;
        r_ray    <= n_ray;
        r_greens <= n_greens;
        r_rd_in  <= n_rd_in;
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> design/gfrt_checker.sv
// Port-level checks for the grid fan ray tracer, bound to the top level.
// Depends on gfrt_pkg and grid_fan_ray_tracer_macros.svh.
`timescale 1ns / 1ps
`include "grid_fan_ray_tracer_macros.svh"

module gfrt_checker import gfrt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // stalled result holds
    `GFRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // a trace occupies the block past its accept
    `GFRT_ASSERT_NEXT(a_trace_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_item.opcode == OP_TRACE), !o_in_ready)

    // a read result is pending after the accept
    `GFRT_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_item.opcode == OP_READ), !o_in_ready)

    // a sighting waiting means its trace is unfinished
    `GFRT_ASSERT_SAME(a_mid_trace, i_clk, i_rst_n, o_out_valid && !o_out_item.last, !o_in_ready)

endmodule

bind grid_fan_ray_tracer gfrt_checker u_gfrt_checker (.*);
